// ----- rtl/tcpq_pkg.sv -----
package tcpq_pkg;

  // Storage geometry.
  localparam int QueueDepth = 16;
  localparam int IdxW       = $clog2(QueueDepth);
  localparam int CountW     = $clog2(QueueDepth + 1);

  // Fixed field widths of the channels.
  localparam int OpW    = 2;
  localparam int IdW    = 16;
  localparam int ClsW   = 2;
  localparam int PosW   = 5;
  localparam int StatW  = 2;
  localparam int OccW   = 5;
  localparam int CmpW   = (CountW > PosW) ? CountW : PosW;

  // Operation codes.
  localparam logic [OpW-1:0] OP_INSERT   = 2'd0;
  localparam logic [OpW-1:0] OP_DISPATCH = 2'd1;
  localparam logic [OpW-1:0] OP_MODIFY   = 2'd2;

  // Result status codes.
  localparam logic [StatW-1:0] ST_OK     = 2'd0;
  localparam logic [StatW-1:0] ST_FULL   = 2'd1;
  localparam logic [StatW-1:0] ST_EMPTY  = 2'd2;
  localparam logic [StatW-1:0] ST_BADPOS = 2'd3;

  // One stored queue entry.
  typedef struct packed {
    logic [ClsW-1:0] cls;
    logic [IdW-1:0]  id;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             capture;
    logic             place_new;
    logic             place_mod;
    logic             take_head;
    logic             take_pos;
    logic             write_res;
    logic             res_disp;
    logic [StatW-1:0] res_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OpW-1:0] op;
    logic           full;
    logic           empty;
    logic           pos_ok;
    logic           out_free;
  } stat_t;

endpackage

// ----- rtl/tcpq_if.sv -----
// Request channel: one queue operation per item.
interface tcpq_req_if import tcpq_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OpW-1:0]  opcode;
  logic [IdW-1:0]  entry_id;
  logic [ClsW-1:0] priority_class;
  logic [PosW-1:0] position;

  modport source (output valid, opcode, entry_id, priority_class, position, input ready);
  modport sink   (input valid, opcode, entry_id, priority_class, position, output ready);
endinterface

// Response channel: one result item per request.
interface tcpq_rsp_if import tcpq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             out_valid;
  logic [IdW-1:0]   out_id;
  logic [ClsW-1:0]  out_class;
  logic [StatW-1:0] status;
  logic [OccW-1:0]  occupancy;

  modport source (output valid, out_valid, out_id, out_class, status, occupancy, input ready);
  modport sink   (input valid, out_valid, out_id, out_class, status, occupancy, output ready);
endinterface

// ----- rtl/tcpq_datapath.sv -----
module tcpq_datapath import tcpq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [OpW-1:0]   opcode_i,
  input  logic [IdW-1:0]   entry_id_i,
  input  logic [ClsW-1:0]  priority_class_i,
  input  logic [PosW-1:0]  position_i,
  input  logic             rsp_ready_i,
  input  cmd_t             cmd_i,
  output stat_t            stat_o,
  output logic             rsp_valid_o,
  output logic             out_valid_o,
  output logic [IdW-1:0]   out_id_o,
  output logic [ClsW-1:0]  out_class_o,
  output logic [StatW-1:0] status_o,
  output logic [OccW-1:0]  occupancy_o
);

  entry_t                slots_q [QueueDepth];
  entry_t                slots_d [QueueDepth];
  logic [CountW-1:0]     count_q, count_d;
  logic [OpW-1:0]        op_q;
  logic [IdW-1:0]        id_q;
  logic [ClsW-1:0]       cls_q;
  logic [PosW-1:0]       pos_q;
  logic [IdW-1:0]        mod_id_q;
  logic [QueueDepth-1:0] keep;
  logic [IdxW-1:0]       pos_idx, take_idx;
  entry_t                place_e;
  logic                  rsp_valid_q;
  logic                  res_vld_q;
  logic [IdW-1:0]        res_id_q;
  logic [ClsW-1:0]       res_cls_q;
  logic [StatW-1:0]      res_stat_q;
  logic [OccW-1:0]       res_occ_q;

  // Request register, loaded when the controller accepts an item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= opcode_i;
      id_q  <= entry_id_i;
      cls_q <= priority_class_i;
      pos_q <= position_i;
    end
  end

  // Position of the entry to remove, as a 0-based slot index.
  assign pos_idx  = IdxW'(pos_q - PosW'(1));
  assign take_idx = cmd_i.take_head ? '0 : pos_idx;

  // Entry to place: a fresh insert or the held entry with its new class.
  assign place_e = cmd_i.place_new ? entry_t'{cls: cls_q, id: id_q}
                                   : entry_t'{cls: cls_q, id: mod_id_q};

  // Each slot decides whether it stays ahead of the new entry.
  always_comb begin
    for (int i = 0; i < QueueDepth; i++) begin
      keep[i] = (CountW'(i) < count_q) && (slots_q[i].cls <= place_e.cls);
    end
  end

  // Per-slot shift: open a gap for a placement, or close one for a removal.
  always_comb begin
    slots_d = slots_q;
    count_d = count_q;
    if (cmd_i.place_new || cmd_i.place_mod) begin
      slots_d[0] = keep[0] ? slots_q[0] : place_e;
      for (int i = 1; i < QueueDepth; i++) begin
        if (keep[i]) begin
          slots_d[i] = slots_q[i];
        end else if (keep[i-1]) begin
          slots_d[i] = place_e;
        end else begin
          slots_d[i] = slots_q[i-1];
        end
      end
      count_d = count_q + CountW'(1);
    end else if (cmd_i.take_head || cmd_i.take_pos) begin
      for (int i = 0; i < QueueDepth - 1; i++) begin
        slots_d[i] = (IdxW'(i) < take_idx) ? slots_q[i] : slots_q[i+1];
      end
      count_d = count_q - CountW'(1);
    end
  end

  // Slot storage holds no reset; only slots below the count are read.
  always_ff @(posedge clk_i) begin
    slots_q <= slots_d;
    if (cmd_i.take_pos) begin
      mod_id_q <= slots_q[take_idx].id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Result register with its handshake flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.write_res) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_res) begin
      res_vld_q  <= cmd_i.res_disp;
      res_id_q   <= cmd_i.res_disp ? slots_q[0].id : '0;
      res_cls_q  <= cmd_i.res_disp ? slots_q[0].cls : '0;
      res_stat_q <= cmd_i.res_status;
      res_occ_q  <= OccW'(count_d);
    end
  end

  // Status toward the controller.
  assign stat_o.op       = op_q;
  assign stat_o.full     = (count_q == CountW'(QueueDepth));
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.pos_ok   = (pos_q != '0) && (CmpW'(pos_q) <= CmpW'(count_q));
  assign stat_o.out_free = !rsp_valid_q || rsp_ready_i;

  assign rsp_valid_o = rsp_valid_q;
  assign out_valid_o = res_vld_q;
  assign out_id_o    = res_id_q;
  assign out_class_o = res_cls_q;
  assign status_o    = res_stat_q;
  assign occupancy_o = res_occ_q;

endmodule

// ----- rtl/tcpq_ctrl.sv -----
module tcpq_ctrl import tcpq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  req_valid_i,
  output logic  req_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_REINS = 2'd2;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequence each operation; results wait until the result register is free.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if ((stat_i.op == OP_MODIFY) && stat_i.pos_ok) begin
          // First half of a modify: pull the entry out of the queue.
          cmd_o.take_pos = 1'b1;
          state_d        = S_REINS;
        end else if (stat_i.out_free) begin
          cmd_o.write_res  = 1'b1;
          cmd_o.res_status = ST_OK;
          case (stat_i.op)
            OP_INSERT: begin
              if (stat_i.full) begin
                cmd_o.res_status = ST_FULL;
              end else begin
                cmd_o.place_new = 1'b1;
              end
            end
            OP_DISPATCH: begin
              if (stat_i.empty) begin
                cmd_o.res_status = ST_EMPTY;
              end else begin
                cmd_o.take_head = 1'b1;
                cmd_o.res_disp  = 1'b1;
              end
            end
            OP_MODIFY: begin
              cmd_o.res_status = ST_BADPOS;
            end
            default: begin
              cmd_o.res_status = ST_OK;
            end
          endcase
          state_d = S_IDLE;
        end
      end
      S_REINS: begin
        // Second half of a modify: place the held entry under its new class.
        if (stat_i.out_free) begin
          cmd_o.place_mod  = 1'b1;
          cmd_o.write_res  = 1'b1;
          cmd_o.res_status = ST_OK;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/three_class_priority_queue.sv -----
// Ordered queue of up to 16 entries, each an identifier and a class
// (0 highest, 2 lowest). Requests arrive on the req channel and every
// request yields exactly one item on the rsp channel, both valid/ready.
// Insert places the entry behind all entries of equal or higher class;
// dispatch removes the head and returns it; modify removes the entry at a
// 1-based position and reinserts it with a new class. Errors (full,
// empty, bad position) are reported in status and leave the queue alone.
// A request passes through the request register and then an execute step
// that writes the result and shifts the slot array; a modify that hits a
// valid position adds a reinsert step. Result writes wait while the result
// register is occupied, and the slot array moves at most one step per cycle.
// Reset empties the queue at once; slot contents are not cleared.
// When the receiver stalls, the result register holds its item, the block
// still accepts one more request and holds it until the result register
// frees.
module three_class_priority_queue import tcpq_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  tcpq_req_if.sink   req,
  tcpq_rsp_if.source rsp
);

  cmd_t  cmd;
  stat_t stat;

  tcpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tcpq_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .opcode_i         (req.opcode),
    .entry_id_i       (req.entry_id),
    .priority_class_i (req.priority_class),
    .position_i       (req.position),
    .rsp_ready_i      (rsp.ready),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .rsp_valid_o      (rsp.valid),
    .out_valid_o      (rsp.out_valid),
    .out_id_o         (rsp.out_id),
    .out_class_o      (rsp.out_class),
    .status_o         (rsp.status),
    .occupancy_o      (rsp.occupancy)
  );

  // The reported occupancy never exceeds the queue depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> (OccW'(rsp.occupancy) <= OccW'(QueueDepth)))
    else $error("occupancy above queue depth");

  // A returned entry always comes with an ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.out_valid) |-> (rsp.status == ST_OK))
    else $error("dispatched entry with error status");

  // Results that carry no entry report zero identifier and class.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && !rsp.out_valid) |-> ((rsp.out_id == '0) && (rsp.out_class == '0)))
    else $error("non-dispatch result carries entry data");

  // One request at a time: no accept in the cycle after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while another is in work");

  // A placement never happens while the queue is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.place_new || cmd.place_mod) |-> !stat.full)
    else $error("placement into a full queue");

endmodule
